// ===== src/mblp_pkg.sv =====
// Shared constants, codes and types of the monochrome bitmap to LCD page reorder block.
package mblp_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT / 8;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int INDEX_W      = 10;
    localparam int DATA_W       = 8;
    localparam int WIDTH_REG_W  = 8;
    localparam int HEIGHT_REG_W = 7;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_INDEX_W  = 2;

    // Frame width in bytes and frame height in pages.
    localparam int WC_W = $clog2(MAX_WIDTH / 8 + 1);
    localparam int HP_W = $clog2(MAX_HEIGHT / 8 + 1);
    localparam logic [WC_W-1:0] WC_MAX = WC_W'(MAX_WIDTH / 8);
    localparam logic [HP_W-1:0] HP_MAX = HP_W'(MAX_HEIGHT / 8);

    localparam int SIZE_W = 12;
    localparam int QUO_W  = 6;
    localparam int STEP_W = 3;
    localparam int DIFF_W = 14;
    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(QUO_W - 1);

    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic DIR_BMP_TO_LCD = 1'b0;
    localparam logic DIR_LCD_TO_BMP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_BASE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } mblp_state_t;

    typedef struct packed {
        logic accept;
        logic check;
        logic div_step;
        logic base;
        logic rd_issue;
        logic load_out;
    } mblp_cmd_t;

    typedef struct packed {
        logic oob;
        logic is_read;
        logic div_last;
        logic read_last;
    } mblp_sts_t;

endpackage

// ===== src/mblp_in_if.sv =====
// Handshake channel that carries one access item into the block.
interface mblp_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [mblp_pkg::INDEX_W-1:0]  byte_index;
    logic [mblp_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output command, output byte_index, output write_data,
                    input ready);
    modport sink   (input valid, input command, input byte_index, input write_data,
                    output ready);
endinterface

// ===== src/mblp_out_if.sv =====
// Handshake channel that carries one result item out of the block.
interface mblp_out_if;
    logic                         valid;
    logic                         ready;
    logic [mblp_pkg::DATA_W-1:0]  read_data;
    logic                         status;

    modport source (output valid, output read_data, output status, input ready);
    modport sink   (input valid, input read_data, input status, output ready);
endinterface

// ===== src/mblp_dp.sv =====
// Datapath: configuration registers, frame store, index divider, address walk and result register.
module mblp_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [mblp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mblp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 command,
    input  logic [mblp_pkg::INDEX_W-1:0]         byte_index,
    input  logic [mblp_pkg::DATA_W-1:0]          write_data,
    input  mblp_pkg::mblp_cmd_t                  cmd,
    output mblp_pkg::mblp_sts_t                  sts,
    output logic [mblp_pkg::DATA_W-1:0]          read_data,
    output logic                                 status
);

    logic                                direction_reg;
    logic [mblp_pkg::WIDTH_REG_W-1:0]    width_reg;
    logic [mblp_pkg::HEIGHT_REG_W-1:0]   height_reg;

    logic                                command_reg;
    logic [mblp_pkg::INDEX_W-1:0]        idx_reg;
    logic [mblp_pkg::DATA_W-1:0]         wdata_reg;
    logic                                oob_reg;

    logic [mblp_pkg::INDEX_W-1:0]        rem_reg;
    logic [mblp_pkg::QUO_W-1:0]          quo_reg;
    logic [mblp_pkg::STEP_W-1:0]         step_reg;
    logic [mblp_pkg::DATA_W-1:0]         divisor_reg;

    logic [mblp_pkg::ADDR_W-1:0]         addr_reg;
    logic [2:0]                          bitsel_reg;
    logic [2:0]                          cnt_reg;
    logic [mblp_pkg::DATA_W-1:0]         rd_byte_reg;
    logic                                rd_pend_reg;
    logic [mblp_pkg::DATA_W-1:0]         acc_reg;
    logic [mblp_pkg::DATA_W-1:0]         read_data_reg;
    logic                                status_reg;

    logic [mblp_pkg::DATA_W-1:0]         frame_store [mblp_pkg::STORE_DEPTH];

    logic [mblp_pkg::WC_W-1:0]           wc_raw;
    logic [mblp_pkg::WC_W-1:0]           wc;
    logic [mblp_pkg::HP_W-1:0]           hp_raw;
    logic [mblp_pkg::HP_W-1:0]           hp;
    logic [8:0]                          frame_units;
    logic [mblp_pkg::SIZE_W-1:0]         frame_size;
    logic                                oob;

    logic [mblp_pkg::DIFF_W-1:0]         trial_sub;
    logic [mblp_pkg::DIFF_W-1:0]         diff;

    logic [6:0]                          row_full;
    logic [5:0]                          row;
    logic [2:0]                          lcd_rows;
    logic [2:0]                          mul_a;
    logic [7:0]                          prod;
    logic [mblp_pkg::ADDR_W-1:0]         base_addr;
    logic [2:0]                          base_bitsel;
    logic [mblp_pkg::ADDR_W-1:0]         addr_next;

    // Effective geometry, saturated to the size of the frame store.
    assign wc_raw      = width_reg[7:3];
    assign wc          = (wc_raw > mblp_pkg::WC_MAX) ? mblp_pkg::WC_MAX : wc_raw;
    assign hp_raw      = height_reg[6:3];
    assign hp          = (hp_raw > mblp_pkg::HP_MAX) ? mblp_pkg::HP_MAX : hp_raw;
    assign frame_units = 9'(wc) * 9'(hp);
    assign frame_size  = {frame_units, 3'b000};
    assign oob         = {2'b00, idx_reg} >= frame_size;

    // One quotient bit per cycle.
    assign trial_sub = mblp_pkg::DIFF_W'(divisor_reg) << step_reg;
    assign diff      = mblp_pkg::DIFF_W'(rem_reg) - trial_sub;

    // The quotient is the page (LCD output) or the row from the top (bitmap output).
    assign row_full = {hp, 3'b000} - 7'd1 - {1'b0, quo_reg};
    assign row      = row_full[5:0];
    assign lcd_rows = 3'(hp - 4'd1 - {1'b0, quo_reg[2:0]});
    assign mul_a    = (direction_reg == mblp_pkg::DIR_LCD_TO_BMP) ? row[5:3] : lcd_rows;
    assign prod     = 8'(mul_a) * 8'(wc);

    always_comb
    begin
        if (direction_reg == mblp_pkg::DIR_LCD_TO_BMP)
        begin
            base_addr   = {prod[6:0], 3'b000} + {3'b000, rem_reg[3:0], 3'b111};
            base_bitsel = ~row[2:0];
            addr_next   = addr_reg - 10'd1;
        end
        else
        begin
            base_addr   = {prod[6:0], 3'b000} + 10'(rem_reg[6:3]);
            base_bitsel = ~rem_reg[2:0];
            addr_next   = addr_reg + 10'(wc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= mblp_pkg::DIR_BMP_TO_LCD;
            width_reg     <= 8'd128;
            height_reg    <= 7'd64;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd_issue;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    mblp_pkg::REG_DIRECTION: direction_reg <= cfg_data[0];
                    mblp_pkg::REG_WIDTH:     width_reg     <= cfg_data;
                    mblp_pkg::REG_HEIGHT:    height_reg    <= cfg_data[6:0];
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            command_reg <= command;
            idx_reg     <= byte_index;
            wdata_reg   <= write_data;
        end
        if (cmd.check)
        begin
            oob_reg     <= oob;
            acc_reg     <= '0;
            rem_reg     <= idx_reg;
            quo_reg     <= '0;
            step_reg    <= mblp_pkg::STEP_FIRST;
            divisor_reg <= (direction_reg == mblp_pkg::DIR_LCD_TO_BMP) ?
                           8'(wc) : {wc[4:0], 3'b000};
        end
        if (cmd.div_step)
        begin
            if (!diff[mblp_pkg::DIFF_W-1])
            begin
                rem_reg           <= diff[mblp_pkg::INDEX_W-1:0];
                quo_reg[step_reg] <= 1'b1;
            end
            step_reg <= step_reg - 3'd1;
        end
        if (cmd.base)
        begin
            addr_reg   <= base_addr;
            bitsel_reg <= base_bitsel;
            cnt_reg    <= '0;
        end
        if (cmd.rd_issue)
        begin
            addr_reg <= addr_next;
            cnt_reg  <= cnt_reg + 3'd1;
        end
        if (rd_pend_reg)
        begin
            acc_reg <= {rd_byte_reg[bitsel_reg], acc_reg[7:1]};
        end
        if (cmd.load_out)
        begin
            read_data_reg <= acc_reg;
            status_reg    <= oob_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check && !oob && command_reg == mblp_pkg::CMD_WRITE)
        begin
            frame_store[idx_reg] <= wdata_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_byte_reg <= frame_store[addr_reg];
        end
    end

    assign sts.oob       = oob;
    assign sts.is_read   = (command_reg == mblp_pkg::CMD_READ);
    assign sts.div_last  = (step_reg == '0);
    assign sts.read_last = (cnt_reg == 3'd7);

    assign read_data = read_data_reg;
    assign status    = status_reg;

endmodule

// ===== src/mblp_ctrl.sv =====
// Controller: sequences check, division, address setup and the eight store reads of one item.
module mblp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mblp_pkg::mblp_sts_t   sts,
    output mblp_pkg::mblp_cmd_t   cmd
);

    mblp_pkg::mblp_state_t state_reg;
    mblp_pkg::mblp_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mblp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            mblp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = mblp_pkg::ST_CHECK;
                end
            end
            mblp_pkg::ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = (sts.oob || !sts.is_read) ? mblp_pkg::ST_DONE : mblp_pkg::ST_DIV;
            end
            mblp_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = mblp_pkg::ST_BASE;
                end
            end
            mblp_pkg::ST_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = mblp_pkg::ST_READ;
            end
            mblp_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                if (sts.read_last)
                begin
                    state_next = mblp_pkg::ST_DRAIN;
                end
            end
            mblp_pkg::ST_DRAIN:
            begin
                state_next = mblp_pkg::ST_DONE;
            end
            mblp_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = mblp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mblp_pkg::ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while its item waits");

    // An accepted item always starts with the range check.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == mblp_pkg::ST_CHECK))
        else $error("accepted item did not enter the range check");

    // The read phase runs until the eighth read has been issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mblp_pkg::ST_READ && !sts.read_last) |=>
        (state_reg == mblp_pkg::ST_READ))
        else $error("read phase left before all eight reads");

    // Writes and flagged items skip the division and the reads.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mblp_pkg::ST_CHECK && (sts.oob || !sts.is_read)) |=>
        (state_reg == mblp_pkg::ST_DONE))
        else $error("write or flagged item entered the gather sequence");

endmodule

// ===== src/mono_bitmap_lcd_page_reorder.sv =====
// Top level of the monochrome frame store that reorders bitmap bytes and LCD page bytes.
//
//   Channel  Role     Carries
//   access   sink     command, byte_index, write_data
//   result   source   read_data, status
//   cfg      write    cfg_write_en, cfg_index, cfg_data
//
// A write or a flagged item passes from acceptance through the range check to the load of its
// result. A read passes through the check, the divider steps, an address setup, eight reads
// of the single frame store port, one per gathered pixel, a drain step to collect and the load.
// The next item can be accepted in the cycle after its result is loaded into the output register.
// The output register holds a result while the sink stalls; processing stalls only when a
// second result is ready before the first has been taken. Reset is asynchronous, active low.
module mono_bitmap_lcd_page_reorder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [mblp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mblp_pkg::CFG_DATA_W-1:0]   cfg_data,
    mblp_in_if.sink                           access,
    mblp_out_if.source                        result
);

    mblp_pkg::mblp_cmd_t cmd;
    mblp_pkg::mblp_sts_t sts;

    mblp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (access.valid),
        .in_ready  (access.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mblp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (access.command),
        .byte_index   (access.byte_index),
        .write_data   (access.write_data),
        .cmd          (cmd),
        .sts          (sts),
        .read_data    (result.read_data),
        .status       (result.status)
    );

endmodule

// ===== dv/mono_bitmap_lcd_page_reorder_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench that drives frame store accesses and checks every converted byte.
module mono_bitmap_lcd_page_reorder_test;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int NUM_PHASES    = 9;
    localparam int PHASE_ITEMS   = 89;
    localparam int NUM_ROWS      = 27;

    localparam logic [mblp_pkg::CFG_INDEX_W-1:0] REG_DIRECTION = mblp_pkg::REG_DIRECTION;
    localparam logic [mblp_pkg::CFG_INDEX_W-1:0] REG_WIDTH     = mblp_pkg::REG_WIDTH;
    localparam logic [mblp_pkg::CFG_INDEX_W-1:0] REG_HEIGHT    = mblp_pkg::REG_HEIGHT;
    localparam logic [mblp_pkg::CFG_INDEX_W-1:0] REG_UNUSED    = 2'd3;
    localparam logic CMD_WRITE = mblp_pkg::CMD_WRITE;
    localparam logic CMD_READ  = mblp_pkg::CMD_READ;

    localparam logic STS_OK    = 1'b0;
    localparam logic STS_RANGE = 1'b1;
    localparam logic ROW_ITEM  = 1'b0;
    localparam logic ROW_REG   = 1'b1;
    localparam logic BY_TABLE  = 1'b1;
    localparam logic BY_MODEL  = 1'b0;

    typedef struct packed {
        logic [mblp_pkg::DATA_W-1:0] read_data;
        logic                        status;
    } frame_reply_t;

    typedef struct packed {
        logic                             kind;
        logic [mblp_pkg::CFG_INDEX_W-1:0] reg_idx;
        logic                             command;
        logic [mblp_pkg::INDEX_W-1:0]     byte_index;
        logic [mblp_pkg::DATA_W-1:0]      value;
        logic                             source;
        logic [mblp_pkg::DATA_W-1:0]      exp_data;
        logic                             exp_status;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd0,    8'hFF, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd1023, 8'hA5, BY_TABLE, 8'h00, STS_OK},
        '{ROW_REG,  REG_HEIGHT,    CMD_WRITE, 10'd0,    8'h07, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd5,    8'h3C, BY_TABLE, 8'h00, STS_RANGE},
        '{ROW_ITEM, REG_DIRECTION, CMD_READ,  10'd0,    8'hFF, BY_TABLE, 8'h00, STS_RANGE},
        '{ROW_REG,  REG_HEIGHT,    CMD_WRITE, 10'd0,    8'hFF, BY_TABLE, 8'h00, STS_OK},
        '{ROW_REG,  REG_WIDTH,     CMD_WRITE, 10'd0,    8'hFF, BY_TABLE, 8'h00, STS_OK},
        '{ROW_REG,  REG_UNUSED,    CMD_WRITE, 10'd0,    8'h08, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd1023, 8'h5A, BY_TABLE, 8'h00, STS_OK},
        '{ROW_REG,  REG_WIDTH,     CMD_WRITE, 10'd0,    8'h0F, BY_TABLE, 8'h00, STS_OK},
        '{ROW_REG,  REG_HEIGHT,    CMD_WRITE, 10'd0,    8'h0F, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd8,    8'h00, BY_TABLE, 8'h00, STS_RANGE},
        '{ROW_ITEM, REG_DIRECTION, CMD_READ,  10'd1023, 8'hFF, BY_TABLE, 8'h00, STS_RANGE},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd1,    8'h80, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd2,    8'h01, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd3,    8'h55, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd4,    8'hAA, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd5,    8'h00, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd6,    8'h7E, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd7,    8'h81, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_READ,  10'd0,    8'h00, BY_MODEL, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_READ,  10'd7,    8'h00, BY_MODEL, 8'h00, STS_OK},
        '{ROW_REG,  REG_DIRECTION, CMD_WRITE, 10'd0,    8'h01, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_READ,  10'd0,    8'h00, BY_MODEL, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_READ,  10'd7,    8'h00, BY_MODEL, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_WRITE, 10'd3,    8'hC3, BY_TABLE, 8'h00, STS_OK},
        '{ROW_ITEM, REG_DIRECTION, CMD_READ,  10'd4,    8'h00, BY_MODEL, 8'h00, STS_OK}
    };

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write_en;
    logic [mblp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mblp_pkg::CFG_DATA_W-1:0]  cfg_data;

    mblp_in_if  access_ch ();
    mblp_out_if result_ch ();

    logic                              direction_setting;
    logic [mblp_pkg::WIDTH_REG_W-1:0]  width_setting;
    logic [mblp_pkg::HEIGHT_REG_W-1:0] height_setting;
    logic [mblp_pkg::DATA_W-1:0]       page_store [mblp_pkg::STORE_DEPTH];
    bit                                stored     [mblp_pkg::STORE_DEPTH];
    frame_reply_t                      pending_replies [$];
    frame_reply_t                      oldest_reply;
    int                                error_count = 0;
    int                                send_idle_pct;
    int                                recv_idle_pct;
    bit                                hold_request;
    bit                                hold_served = 1'b0;
    int                                hold_left = 0;

    mono_bitmap_lcd_page_reorder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .access       (access_ch),
        .result       (result_ch)
    );

    function automatic int frame_width();
        int w;
        w = int'(width_setting & 8'hF8);
        return (w > mblp_pkg::MAX_WIDTH) ? (mblp_pkg::MAX_WIDTH & ~7) : w;
    endfunction

    function automatic int frame_height();
        int h;
        h = int'(height_setting & 7'h78);
        return (h > mblp_pkg::MAX_HEIGHT) ? (mblp_pkg::MAX_HEIGHT & ~7) : h;
    endfunction

    // Collects the eight pixels of one converted byte; gap names a stored byte not yet written.
    function automatic logic [mblp_pkg::DATA_W-1:0] gather_byte(input int idx, output int gap);
        logic [mblp_pkg::DATA_W-1:0] bits;
        int w;
        int h;
        int point;
        int row;
        int col;
        int addr;
        int bit_pos;
        w    = frame_width();
        h    = frame_height();
        bits = '0;
        gap  = -1;
        for (int b = 0; b < 8; b++)
        begin
            if (direction_setting == mblp_pkg::DIR_BMP_TO_LCD)
            begin
                col     = idx % w;
                row     = (idx / w) * 8 + 7 - b;
                point   = (h - 1 - row) * w + col;
                addr    = point / 8;
                bit_pos = 7 - point % 8;
            end
            else
            begin
                point   = idx * 8 + 7 - b;
                row     = h - 1 - point / w;
                col     = point % w;
                addr    = (row / 8) * w + col;
                bit_pos = 7 - row % 8;
            end
            if (!stored[addr])
                gap = addr;
            bits[b] = page_store[addr][bit_pos];
        end
        return bits;
    endfunction

    function automatic frame_reply_t predict_access(input logic cmd, input int idx,
                                                    input logic [mblp_pkg::DATA_W-1:0] data);
        frame_reply_t reply;
        int           gap;
        reply.read_data = '0;
        reply.status    = STS_OK;
        if (idx >= frame_width() * frame_height() / 8)
            reply.status = STS_RANGE;
        else if (cmd == mblp_pkg::CMD_WRITE)
        begin
            page_store[idx] = data;
            stored[idx]     = 1'b1;
        end
        else
            reply.read_data = gather_byte(idx, gap);
        return reply;
    endfunction

    task automatic send_access(input logic cmd, input logic [mblp_pkg::INDEX_W-1:0] idx,
                               input logic [mblp_pkg::DATA_W-1:0] data, input logic by_table,
                               input frame_reply_t typed);
        frame_reply_t model_reply;
        while ($urandom_range(99) < send_idle_pct)
        begin
            access_ch.valid <= 1'b0;
            @(posedge clk);
        end
        access_ch.valid      <= 1'b1;
        access_ch.command    <= cmd;
        access_ch.byte_index <= idx;
        access_ch.write_data <= data;
        do
            @(posedge clk);
        while (!access_ch.ready);
        model_reply = predict_access(cmd, idx, data);
        pending_replies.push_back(by_table ? typed : model_reply);
    endtask

    task automatic set_register(input logic [mblp_pkg::CFG_INDEX_W-1:0] reg_idx,
                                input logic [mblp_pkg::CFG_DATA_W-1:0] value);
        access_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= reg_idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (reg_idx)
            mblp_pkg::REG_DIRECTION: direction_setting = value[0];
            mblp_pkg::REG_WIDTH:     width_setting     = value[mblp_pkg::WIDTH_REG_W-1:0];
            mblp_pkg::REG_HEIGHT:    height_setting    = value[mblp_pkg::HEIGHT_REG_W-1:0];
            default:                 ;
        endcase
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver checks each result item against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result item, read_data %h status %b", $time,
                         result_ch.read_data, result_ch.status);
                error_count++;
            end
            else
            begin
                oldest_reply = pending_replies.pop_front();
                if (result_ch.read_data !== oldest_reply.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             oldest_reply.read_data, result_ch.read_data);
                    error_count++;
                end
                if (result_ch.status !== oldest_reply.status)
                begin
                    $display("%0t: status expected %b actual %b", $time,
                             oldest_reply.status, result_ch.status);
                    error_count++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (hold_request && !hold_served)
        begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((access_ch.valid && access_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t                   row;
        logic                        cmd;
        logic [mblp_pkg::DATA_W-1:0] data;
        logic [mblp_pkg::DATA_W-1:0] w_value;
        logic [mblp_pkg::DATA_W-1:0] h_value;
        logic [mblp_pkg::DATA_W-1:0] dir_value;
        int                          idx;
        int                          size;
        int                          gap;
        hold_request         = 1'b0;
        send_idle_pct        = 16;
        recv_idle_pct        = 71;
        rst_n                = 1'b0;
        cfg_write_en         = 1'b0;
        cfg_index            = mblp_pkg::REG_DIRECTION;
        cfg_data             = '0;
        access_ch.valid      = 1'b0;
        access_ch.command    = mblp_pkg::CMD_WRITE;
        access_ch.byte_index = '0;
        access_ch.write_data = '0;
        direction_setting    = mblp_pkg::DIR_BMP_TO_LCD;
        width_setting        = mblp_pkg::WIDTH_REG_W'(mblp_pkg::MAX_WIDTH);
        height_setting       = mblp_pkg::HEIGHT_REG_W'(mblp_pkg::MAX_HEIGHT);
        foreach (stored[i])
            stored[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_REG)
                set_register(row.reg_idx, row.value);
            else
                send_access(row.command, row.byte_index, row.value, row.source,
                            frame_reply_t'{row.exp_data, row.exp_status});
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase / 3)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 71;
                end
                1:
                begin
                    send_idle_pct = 71;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // The low three bits of both sizes are filled with noise, which the block drops.
            case (phase % 3)
                0:
                begin
                    w_value = (phase == 3) ? 8'hFF :
                              8'(mblp_pkg::MAX_WIDTH + $urandom_range(7));
                    h_value = (phase == 3) ? 8'h7F :
                              8'(mblp_pkg::MAX_HEIGHT + $urandom_range(7));
                end
                1:
                begin
                    w_value = 8'(8 + $urandom_range(7));
                    h_value = 8'(8 + $urandom_range(7));
                end
                default:
                begin
                    w_value = 8'(8 * $urandom_range(16, 1) + $urandom_range(7));
                    h_value = 8'(8 * $urandom_range(8, 1) + $urandom_range(7));
                end
            endcase
            dir_value = (phase % 2 == 1) ? 8'(mblp_pkg::DIR_LCD_TO_BMP) :
                        8'(mblp_pkg::DIR_BMP_TO_LCD);
            set_register(mblp_pkg::REG_DIRECTION, dir_value);
            set_register(mblp_pkg::REG_WIDTH, w_value);
            set_register(mblp_pkg::REG_HEIGHT, h_value);
            if (phase == 6)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                size = frame_width() * frame_height() / 8;
                data = mblp_pkg::DATA_W'($urandom_range(255));
                if (size < mblp_pkg::STORE_DEPTH && (size == 0 || $urandom_range(99) < 8))
                    idx = $urandom_range(mblp_pkg::STORE_DEPTH - 1, size);
                else
                    idx = $urandom_range(size - 1);
                cmd = ($urandom_range(99) < 40) ? mblp_pkg::CMD_WRITE : mblp_pkg::CMD_READ;
                // A read that would gather an unwritten byte becomes a write of that byte.
                if (cmd == mblp_pkg::CMD_READ && idx < size)
                begin
                    void'(gather_byte(idx, gap));
                    if (gap >= 0)
                    begin
                        cmd = mblp_pkg::CMD_WRITE;
                        idx = gap;
                    end
                end
                send_access(cmd, mblp_pkg::INDEX_W'(idx), data, BY_MODEL, frame_reply_t'('0));
            end
        end

        access_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
